FILE: hdl/pdbp_pkg.sv
// shared types, constants and helper functions of the process-data bit packer
package pdbp_pkg;

  localparam int NUM_FIELDS = 4;
  localparam int FIELD_W    = 32;
  localparam int SIZE_W     = 6;
  localparam int IDX_W      = 2;
  localparam int CNT_W      = 3;
  localparam int DIR_W      = 2;
  localparam int POS_W      = 8;
  localparam int OFS_W      = 5;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int BCNT_W     = 3;

  localparam logic [BYTE_W-1:0] FAULT_BYTE    = 8'h00;
  localparam logic [DIR_W-1:0]  DIR_TO_HOST   = 2'd0;
  localparam logic [DIR_W-1:0]  DIR_FROM_HOST = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_EXCHANGE = 2'd2,
    CMD_HOST     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_COUNT = 3'd0,
    REG_SIZE0 = 3'd1,
    REG_SIZE1 = 3'd2,
    REG_SIZE2 = 3'd3,
    REG_SIZE3 = 3'd4,
    REG_DIR   = 3'd5
  } reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [NUM_FIELDS-1:0][SIZE_W-1:0] size;
    logic [NUM_FIELDS-1:0][DIR_W-1:0]  dir;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] field;
    logic [OFS_W-1:0] offset;
  } loc_t;

  typedef struct packed {
    logic               load;
    logic [FIELD_W-1:0] read_value;
    logic [BYTE_W-1:0]  frame_byte;
    logic               last;
  } emit_t;

  function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] s);
    size_eff = (s > SIZE_W'(FIELD_W)) ? SIZE_W'(FIELD_W) : s;
  endfunction

  function automatic logic [FIELD_W-1:0] size_mask(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] e;
    e = size_eff(s);
    if (e == SIZE_W'(FIELD_W)) size_mask = '1;
    else size_mask = (FIELD_W'(1) << e) - FIELD_W'(1);
  endfunction

  function automatic logic field_used(input cfg_t c, input logic [IDX_W-1:0] i);
    field_used = CNT_W'(i) < c.count;
  endfunction

  // bits a field puts into the reply frame
  function automatic logic [SIZE_W-1:0] to_bits(input cfg_t c, input logic [IDX_W-1:0] i);
    to_bits = (field_used(c, i) && c.dir[i] != DIR_FROM_HOST) ? size_eff(c.size[i]) : '0;
  endfunction

  // bits a field takes from the host stream
  function automatic logic [SIZE_W-1:0] from_bits(input cfg_t c, input logic [IDX_W-1:0] i);
    from_bits = (field_used(c, i) && c.dir[i] != DIR_TO_HOST) ? size_eff(c.size[i]) : '0;
  endfunction

endpackage

FILE: hdl/pdbp_if.sv
// valid/ready channel interfaces for command items and result items
interface pdbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [pdbp_pkg::IDX_W-1:0]    field_index;
  logic [pdbp_pkg::FIELD_W-1:0]  value;
  logic [pdbp_pkg::BYTE_W-1:0]   host_byte;

  modport source(output valid, command, field_index, value, host_byte, input ready);
  modport sink(input valid, command, field_index, value, host_byte, output ready);
endinterface

interface pdbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdbp_pkg::FIELD_W-1:0]  read_value;
  logic [pdbp_pkg::BYTE_W-1:0]   frame_byte;
  logic                          last;

  modport source(output valid, read_value, frame_byte, last, input ready);
  modport sink(input valid, read_value, frame_byte, last, output ready);
endinterface

FILE: hdl/process_data_bit_packer.sv
// top level: a local write is stored when taken; a local read result goes through the result state
// into the output register; begin exchange: the fault byte goes out first, then frame bits are
// shifted one by one through the bit-serial field shift register, with seek, pad and emit steps;
// fault and emit wait while the output register is full; host byte: unpacked one bit per cycle
// one item at a time; results wait in an output register that parts the two sides
// synchronous reset clears field values, unpack cursor and config to reset values
module process_data_bit_packer (
  input  logic                          clk,
  input  logic                          rst,
  pdbp_in_if.sink                       req,
  pdbp_out_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [pdbp_pkg::DATA_W-1:0]   pwdata,
  output logic [pdbp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  pdbp_pkg::cfg_t  cfg;
  pdbp_pkg::emit_t emit;
  logic            out_free;

  pdbp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdbp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .out_free (out_free),
    .emit     (emit)
  );

  // output register
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit.load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      rsp.read_value <= emit.read_value;
      rsp.frame_byte <= emit.frame_byte;
      rsp.last       <= emit.last;
    end
  end

endmodule

FILE: hdl/pdbp_apb_regs.sv
// apb configuration registers: field count, field sizes and directions
module pdbp_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdbp_pkg::ADDR_W-1:0]   paddr,
  input  logic [pdbp_pkg::DATA_W-1:0]   pwdata,
  output logic [pdbp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pdbp_pkg::cfg_t                cfg
);

  localparam int ADDR_IDX_HI = pdbp_pkg::ADDR_W - 1;

  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[ADDR_IDX_HI:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count <= '0;
      for (int i = 0; i < pdbp_pkg::NUM_FIELDS; i++) begin
        cfg.size[i] <= pdbp_pkg::SIZE_W'(8);
      end
      cfg.dir <= '0;
    end else if (wr_en) begin
      unique case (pdbp_pkg::reg_t'(reg_sel))
        pdbp_pkg::REG_COUNT: cfg.count   <= pwdata[pdbp_pkg::CNT_W-1:0];
        pdbp_pkg::REG_SIZE0: cfg.size[0] <= pwdata[pdbp_pkg::SIZE_W-1:0];
        pdbp_pkg::REG_SIZE1: cfg.size[1] <= pwdata[pdbp_pkg::SIZE_W-1:0];
        pdbp_pkg::REG_SIZE2: cfg.size[2] <= pwdata[pdbp_pkg::SIZE_W-1:0];
        pdbp_pkg::REG_SIZE3: cfg.size[3] <= pwdata[pdbp_pkg::SIZE_W-1:0];
        pdbp_pkg::REG_DIR:   cfg.dir     <= pwdata[pdbp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (pdbp_pkg::reg_t'(reg_sel))
      pdbp_pkg::REG_COUNT: prdata = pdbp_pkg::DATA_W'(cfg.count);
      pdbp_pkg::REG_SIZE0: prdata = pdbp_pkg::DATA_W'(cfg.size[0]);
      pdbp_pkg::REG_SIZE1: prdata = pdbp_pkg::DATA_W'(cfg.size[1]);
      pdbp_pkg::REG_SIZE2: prdata = pdbp_pkg::DATA_W'(cfg.size[2]);
      pdbp_pkg::REG_SIZE3: prdata = pdbp_pkg::DATA_W'(cfg.size[3]);
      pdbp_pkg::REG_DIR:   prdata = pdbp_pkg::DATA_W'(cfg.dir);
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: hdl/pdbp_locate.sv
// maps a host bit position to the from-host field and bit offset it lands in
module pdbp_locate (
  input  pdbp_pkg::cfg_t                cfg,
  input  logic [pdbp_pkg::POS_W-1:0]    pos,
  output pdbp_pkg::loc_t                loc,
  output logic [pdbp_pkg::POS_W-1:0]    total
);

  logic [pdbp_pkg::POS_W-1:0] base;
  logic [pdbp_pkg::POS_W-1:0] stop;

  always_comb begin
    base = '0;
    stop = '0;
    loc  = '0;
    for (int i = 0; i < pdbp_pkg::NUM_FIELDS; i++) begin
      stop = base + pdbp_pkg::POS_W'(pdbp_pkg::from_bits(cfg, pdbp_pkg::IDX_W'(i)));
      if (!loc.hit && pos < stop) begin
        loc.hit    = 1'b1;
        loc.field  = pdbp_pkg::IDX_W'(i);
        loc.offset = pdbp_pkg::OFS_W'(pos - base);
      end
      base = stop;
    end
    total = base;
  end

endmodule

FILE: hdl/pdbp_core.sv
// field store plus bit-serial frame packer and host byte unpacker
module pdbp_core (
  input  logic              clk,
  input  logic              rst,
  input  pdbp_pkg::cfg_t    cfg,
  pdbp_in_if.sink           req,
  input  logic              out_free,
  output pdbp_pkg::emit_t   emit
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RESULT, ST_FAULT, ST_SEEK, ST_SHIFT, ST_PAD, ST_EMIT, ST_UNPACK
  } state_t;

  state_t                                                state;
  logic [pdbp_pkg::NUM_FIELDS-1:0][pdbp_pkg::FIELD_W-1:0] field_values;
  logic [pdbp_pkg::POS_W-1:0]   cursor;
  logic [pdbp_pkg::POS_W-1:0]   rem;
  logic [pdbp_pkg::IDX_W-1:0]   fidx;
  logic [pdbp_pkg::SIZE_W-1:0]  fcnt;
  logic [pdbp_pkg::FIELD_W-1:0] fshift;
  logic [pdbp_pkg::BYTE_W-1:0]  bbyte;
  logic [pdbp_pkg::BCNT_W-1:0]  bcnt;
  logic [pdbp_pkg::BYTE_W-1:0]  hshift;
  logic [pdbp_pkg::BCNT_W-1:0]  ucnt;
  logic [pdbp_pkg::FIELD_W-1:0] res_value;

  logic [pdbp_pkg::IDX_W-1:0]   rd_addr;
  logic [pdbp_pkg::FIELD_W-1:0] rd_data;
  logic [pdbp_pkg::POS_W-1:0]   total_to;
  logic [pdbp_pkg::POS_W-1:0]   total_from;
  logic [pdbp_pkg::SIZE_W-1:0]  seek_bits;
  pdbp_pkg::loc_t               loc;
  logic                         accept;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // one read port on the field store
  assign rd_addr   = (state == ST_IDLE) ? req.field_index : fidx;
  assign rd_data   = field_values[rd_addr];
  assign seek_bits = pdbp_pkg::to_bits(cfg, fidx);

  always_comb begin
    total_to = '0;
    for (int i = 0; i < pdbp_pkg::NUM_FIELDS; i++) begin
      total_to = total_to + pdbp_pkg::POS_W'(pdbp_pkg::to_bits(cfg, pdbp_pkg::IDX_W'(i)));
    end
  end

  pdbp_locate u_locate (
    .cfg   (cfg),
    .pos   (cursor),
    .loc   (loc),
    .total (total_from)
  );

  always_comb begin
    emit = '0;
    case (state)
      ST_RESULT: begin
        emit.load       = out_free;
        emit.read_value = res_value;
        emit.last       = 1'b1;
      end
      ST_FAULT: begin
        emit.load       = out_free;
        emit.frame_byte = pdbp_pkg::FAULT_BYTE;
        emit.last       = (rem == '0);
      end
      ST_EMIT: begin
        emit.load       = out_free;
        emit.frame_byte = bbyte;
        emit.last       = (rem == '0);
      end
      default: emit = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      field_values <= '0;
      cursor       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (pdbp_pkg::cmd_t'(req.command))
              pdbp_pkg::CMD_WRITE: begin
                field_values[req.field_index] <= req.value &
                  pdbp_pkg::size_mask(cfg.size[req.field_index]);
              end
              pdbp_pkg::CMD_READ: begin
                res_value <= rd_data;
                state     <= ST_RESULT;
              end
              pdbp_pkg::CMD_EXCHANGE: begin
                cursor <= '0;
                rem    <= total_to;
                fidx   <= '0;
                fcnt   <= '0;
                bcnt   <= '0;
                state  <= ST_FAULT;
              end
              pdbp_pkg::CMD_HOST: begin
                hshift <= req.host_byte;
                ucnt   <= '0;
                state  <= ST_UNPACK;
              end
            endcase
          end
        end
        ST_RESULT: begin
          if (out_free) state <= ST_IDLE;
        end
        ST_FAULT: begin
          if (out_free) state <= (rem == '0) ? ST_IDLE : ST_SEEK;
        end
        ST_SEEK: begin
          // skip fields that put nothing into the frame
          if (seek_bits != '0) begin
            fshift <= rd_data;
            fcnt   <= seek_bits;
            state  <= ST_SHIFT;
          end else begin
            fidx <= fidx + pdbp_pkg::IDX_W'(1);
          end
        end
        ST_SHIFT: begin
          bbyte  <= {fshift[0], bbyte[pdbp_pkg::BYTE_W-1:1]};
          fshift <= fshift >> 1;
          bcnt   <= bcnt + pdbp_pkg::BCNT_W'(1);
          rem    <= rem - pdbp_pkg::POS_W'(1);
          fcnt   <= fcnt - pdbp_pkg::SIZE_W'(1);
          priority if (bcnt == '1) begin
            state <= ST_EMIT;
          end else if (rem == pdbp_pkg::POS_W'(1)) begin
            state <= ST_PAD;
          end else if (fcnt == pdbp_pkg::SIZE_W'(1)) begin
            fidx  <= fidx + pdbp_pkg::IDX_W'(1);
            state <= ST_SEEK;
          end
        end
        ST_PAD: begin
          // zero fill of a partial last byte
          bbyte <= {1'b0, bbyte[pdbp_pkg::BYTE_W-1:1]};
          bcnt  <= bcnt + pdbp_pkg::BCNT_W'(1);
          if (bcnt == '1) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            priority if (rem == '0) begin
              state <= ST_IDLE;
            end else if (fcnt == '0) begin
              fidx  <= fidx + pdbp_pkg::IDX_W'(1);
              state <= ST_SEEK;
            end else begin
              state <= ST_SHIFT;
            end
          end
        end
        ST_UNPACK: begin
          if (!loc.hit) begin
            // cursor saturates at the from-host total
            cursor <= total_from;
            state  <= ST_IDLE;
          end else begin
            field_values[loc.field][loc.offset] <= hshift[0];
            hshift <= hshift >> 1;
            cursor <= cursor + pdbp_pkg::POS_W'(1);
            ucnt   <= ucnt + pdbp_pkg::BCNT_W'(1);
            if (ucnt == '1) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_exchange_clears_cursor: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == pdbp_pkg::CMD_EXCHANGE) |=> (cursor == '0))
    else $error("cursor not cleared by begin exchange");

  a_pad_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) |-> (rem == '0))
    else $error("padding while frame bits remain");

  a_seek_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK) |-> (rem != '0))
    else $error("field seek with no frame bits left");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> out_free)
    else $error("result loaded into a full output register");

  a_unpack_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNPACK && loc.hit) |-> (cursor < total_from))
    else $error("host bit placed past the from-host total");

endmodule

FILE: verif/tb.sv
// testbench of the process-data bit packer: directed table, then random phases against a predictor
module tb;

  localparam int STALL_LIMIT = 5000;
  localparam int QUIET_CYCLES = 16;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 38;
  localparam int NUM_PHASES = 9;
  localparam int FRAME_BITS = pdbp_pkg::BYTE_W + pdbp_pkg::NUM_FIELDS * pdbp_pkg::FIELD_W;

  typedef struct packed {
    pdbp_pkg::cmd_t                cmd;
    logic [pdbp_pkg::IDX_W-1:0]    idx;
    logic [pdbp_pkg::FIELD_W-1:0]  value;
    logic [pdbp_pkg::BYTE_W-1:0]   hb;
  } cmd_item_t;

  typedef struct packed {
    logic [pdbp_pkg::FIELD_W-1:0] read_value;
    logic [pdbp_pkg::BYTE_W-1:0]  frame_byte;
    logic                         last;
  } reply_t;

  typedef struct packed {
    logic                         is_reg;
    pdbp_pkg::reg_t               reg_sel;
    logic [pdbp_pkg::DATA_W-1:0]  data;
    cmd_item_t                    item;
    logic                         typed;
    reply_t                       reply;
  } script_row_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pdbp_pkg::ADDR_W-1:0]  paddr;
  logic [pdbp_pkg::DATA_W-1:0]  pwdata;
  logic [pdbp_pkg::DATA_W-1:0]  prdata;
  logic                         pready;

  pdbp_in_if  req ();
  pdbp_out_if rsp ();

  process_data_bit_packer dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [pdbp_pkg::FIELD_W-1:0] field_model [pdbp_pkg::NUM_FIELDS];
  int unsigned                  host_cursor;
  logic [pdbp_pkg::CNT_W-1:0]   cfg_count;
  logic [pdbp_pkg::SIZE_W-1:0]  cfg_size [pdbp_pkg::NUM_FIELDS];
  logic [7:0]                   cfg_dir;

  reply_t      reply_q [$];
  script_row_t script [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_asks;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_run;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned live_fields();
    return (cfg_count > pdbp_pkg::NUM_FIELDS) ? pdbp_pkg::NUM_FIELDS : int'(cfg_count);
  endfunction

  function automatic int unsigned width_of(input int unsigned i);
    return (cfg_size[i] > pdbp_pkg::FIELD_W) ? pdbp_pkg::FIELD_W : int'(cfg_size[i]);
  endfunction

  function automatic logic [pdbp_pkg::DIR_W-1:0] dir_of(input int unsigned i);
    return cfg_dir[2*i +: 2];
  endfunction

  function automatic logic [pdbp_pkg::FIELD_W-1:0] low_mask(input int unsigned w);
    return (w >= pdbp_pkg::FIELD_W) ? {pdbp_pkg::FIELD_W{1'b1}} :
           (pdbp_pkg::FIELD_W'(1) << w) - pdbp_pkg::FIELD_W'(1);
  endfunction

  function automatic int unsigned host_bit_total();
    int unsigned i;
    int unsigned t;
    t = 0;
    for (i = 0; i < live_fields(); i++)
      if (dir_of(i) != pdbp_pkg::DIR_TO_HOST) t += width_of(i);
    return t;
  endfunction

  // host bits land in the from-host and bidirectional fields, in field order
  function automatic void place_host_bit(input int unsigned p, input logic b);
    int unsigned i;
    int unsigned base;
    base = 0;
    for (i = 0; i < live_fields(); i++) begin
      if (dir_of(i) != pdbp_pkg::DIR_TO_HOST) begin
        if (p < base + width_of(i)) begin
          field_model[i][p - base] = b;
          return;
        end
        base += width_of(i);
      end
    end
  endfunction

  task automatic predict_reply(input cmd_item_t it);
    logic [FRAME_BITS-1:0] frame;
    reply_t                r;
    int unsigned           pos;
    int unsigned           nbytes;
    int unsigned           total;
    int unsigned           i;
    int unsigned           b;
    case (it.cmd)
      pdbp_pkg::CMD_WRITE: begin
        field_model[it.idx] = it.value & low_mask(width_of(it.idx));
      end
      pdbp_pkg::CMD_READ: begin
        r.read_value = field_model[it.idx];
        r.frame_byte = 8'h00;
        r.last = 1'b1;
        reply_q.push_back(r);
      end
      pdbp_pkg::CMD_EXCHANGE: begin
        frame = '0;
        frame[pdbp_pkg::BYTE_W-1:0] = pdbp_pkg::FAULT_BYTE;
        pos = pdbp_pkg::BYTE_W;
        for (i = 0; i < live_fields(); i++) begin
          if (dir_of(i) != pdbp_pkg::DIR_FROM_HOST) begin
            for (b = 0; b < width_of(i); b++) begin
              frame[pos] = field_model[i][b];
              pos++;
            end
          end
        end
        nbytes = (pos + 7) / 8;
        for (i = 0; i < nbytes; i++) begin
          r.read_value = '0;
          r.frame_byte = frame[8*i +: 8];
          r.last = (i == nbytes - 1);
          reply_q.push_back(r);
        end
        host_cursor = 0;
      end
      default: begin
        total = host_bit_total();
        for (b = 0; b < 8; b++)
          if (host_cursor + b < total) place_host_bit(host_cursor + b, it.hb[b]);
        host_cursor += 8;
        if (host_cursor > total) host_cursor = total;
      end
    endcase
  endtask

  task automatic offer(input cmd_item_t it, input logic typed, input reply_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.command     <= it.cmd;
    req.field_index <= it.idx;
    req.value       <= it.value;
    req.host_byte   <= it.hb;
    predict_reply(it);
    // typed rows yield one result, which the table states directly
    if (typed) reply_q[reply_q.size() - 1] = want;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain(input int unsigned extra);
    req.valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input pdbp_pkg::reg_t r, input logic [pdbp_pkg::DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pdbp_pkg::ADDR_W'(int'(r) * 4);
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      pdbp_pkg::REG_COUNT: cfg_count = d[pdbp_pkg::CNT_W-1:0];
      pdbp_pkg::REG_SIZE0, pdbp_pkg::REG_SIZE1, pdbp_pkg::REG_SIZE2, pdbp_pkg::REG_SIZE3:
        cfg_size[int'(r) - int'(pdbp_pkg::REG_SIZE0)] = d[pdbp_pkg::SIZE_W-1:0];
      pdbp_pkg::REG_DIR:   cfg_dir = d[7:0];
      default: ;
    endcase
  endtask

  task automatic set_fields(input int unsigned cnt, input int unsigned s0, input int unsigned s1,
                            input int unsigned s2, input int unsigned s3, input int unsigned dirs);
    write_reg(pdbp_pkg::REG_COUNT, cnt);
    write_reg(pdbp_pkg::REG_SIZE0, s0);
    write_reg(pdbp_pkg::REG_SIZE1, s1);
    write_reg(pdbp_pkg::REG_SIZE2, s2);
    write_reg(pdbp_pkg::REG_SIZE3, s3);
    write_reg(pdbp_pkg::REG_DIR, dirs);
  endtask

  task automatic cfg_row(input pdbp_pkg::reg_t r, input logic [pdbp_pkg::DATA_W-1:0] d);
    script_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_sel = r;
    row.data = d;
    script.push_back(row);
  endtask

  task automatic cmd_row(input pdbp_pkg::cmd_t c, input logic [pdbp_pkg::IDX_W-1:0] idx,
                         input logic [pdbp_pkg::FIELD_W-1:0] v,
                         input logic [pdbp_pkg::BYTE_W-1:0] hb, input logic typed,
                         input logic [pdbp_pkg::FIELD_W-1:0] rv,
                         input logic [pdbp_pkg::BYTE_W-1:0] fb);
    script_row_t row;
    row = '0;
    row.item.cmd = c;
    row.item.idx = idx;
    row.item.value = v;
    row.item.hb = hb;
    row.typed = typed;
    row.reply.read_value = rv;
    row.reply.frame_byte = fb;
    row.reply.last = 1'b1;
    script.push_back(row);
  endtask

  function automatic int unsigned size_pick();
    int unsigned k;
    k = $urandom_range(0, 7);
    case (k)
      0: return 0;
      1: return 1;
      2: return pdbp_pkg::FIELD_W;
      3: return 63;
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  function automatic cmd_item_t random_item(input pdbp_pkg::cmd_t c);
    cmd_item_t it;
    int unsigned k;
    it.cmd = c;
    it.idx = pdbp_pkg::IDX_W'($urandom_range(0, pdbp_pkg::NUM_FIELDS - 1));
    it.hb = pdbp_pkg::BYTE_W'($urandom_range(0, 255));
    k = $urandom_range(0, 7);
    if (k == 0) it.value = '1;
    else if (k == 1) it.value = '0;
    else it.value = $urandom;
    return it;
  endfunction

  task automatic run_phase(input int unsigned n, input logic pause_midway);
    cmd_item_t   it;
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    int unsigned j;
    logic        paused;
    logic        counts;
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (pause_midway && !paused && sent >= n / 2) begin
        drain(0);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // exchange followed by a run of host bytes, locals mixed in now and then
        offer(random_item(pdbp_pkg::CMD_EXCHANGE), 1'b0, '0);
        sent++;
        burst = $urandom_range(0, (host_bit_total() + 7) / 8 + 1);
        for (j = 0; j < burst; j++) begin
          if ($urandom_range(0, 5) == 0) begin
            offer(random_item(($urandom_range(0, 1) == 0) ? pdbp_pkg::CMD_WRITE :
                              pdbp_pkg::CMD_READ), 1'b0, '0);
            sent++;
          end
          counts = host_cursor < host_bit_total();
          offer(random_item(pdbp_pkg::CMD_HOST), 1'b0, '0);
          if (counts) sent++;
        end
      end else if (pick < 70) begin
        offer(random_item(pdbp_pkg::CMD_WRITE), 1'b0, '0);
        sent++;
      end else if (pick < 95) begin
        offer(random_item(pdbp_pkg::CMD_READ), 1'b0, '0);
        sent++;
      end else begin
        counts = host_cursor < host_bit_total();
        offer(random_item(pdbp_pkg::CMD_HOST), 1'b0, '0);
        if (counts) sent++;
      end
    end
  endtask

  // result side: check each item, then choose ready for the next cycle
  initial begin
    reply_t got;
    reply_t want;
    rsp.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp.ready <= 1'b0;
      end else begin
        if (rsp.valid && rsp.ready) begin
          got.read_value = rsp.read_value;
          got.frame_byte = rsp.frame_byte;
          got.last = rsp.last;
          if (reply_q.size() == 0) begin
            $error("unexpected result: read_value %h frame_byte %h last %b",
                   got.read_value, got.frame_byte, got.last);
            mismatches++;
          end else begin
            want = reply_q.pop_front();
            if (got.read_value !== want.read_value) begin
              $error("read_value: expected %h, got %h", want.read_value, got.read_value);
              mismatches++;
            end
            if (got.frame_byte !== want.frame_byte) begin
              $error("frame_byte: expected %h, got %h", want.frame_byte, got.frame_byte);
              mismatches++;
            end
            if (got.last !== want.last) begin
              $error("last: expected %b, got %b", want.last, got.last);
              mismatches++;
            end
          end
        end
        if (hold_asks != hold_seen) begin
          hold_seen = hold_asks;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
      end
    end
  end

  initial begin
    quiet_run = 0;
    while (quiet_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_run = 0;
      else quiet_run++;
    end
    $display("process_data_bit_packer regression: fail");
    $finish;
  end

  initial begin
    int unsigned k;
    int unsigned ph;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req.valid       <= 1'b0;
    req.command     <= pdbp_pkg::CMD_WRITE;
    req.field_index <= '0;
    req.value       <= '0;
    req.host_byte   <= '0;
    hold_asks = 0;
    src_idle_pct = 15;
    snk_idle_pct = 50;
    for (k = 0; k < pdbp_pkg::NUM_FIELDS; k++) begin
      field_model[k] = '0;
      cfg_size[k] = 8;
    end
    host_cursor = 0;
    cfg_count = '0;
    cfg_dir = '0;

    // reset configuration: no fields in use, 8-bit sizes
    cmd_row(pdbp_pkg::CMD_READ,     0, 32'h0,         8'h00, 1, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_WRITE,    3, 32'hFFFF_FFFF, 8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_READ,     3, 32'h0,         8'h00, 1, 32'h0000_00FF, 8'h00);
    cmd_row(pdbp_pkg::CMD_EXCHANGE, 0, 32'h0, 8'h00, 1, 32'h0, pdbp_pkg::FAULT_BYTE);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'hA5, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_READ,     0, 32'h0,         8'h00, 1, 32'h0,         8'h00);
    // both ways, to host, from host with zero size, both ways with oversize
    cfg_row(pdbp_pkg::REG_COUNT, 4);
    cfg_row(pdbp_pkg::REG_SIZE0, 32);
    cfg_row(pdbp_pkg::REG_SIZE1, 1);
    cfg_row(pdbp_pkg::REG_SIZE2, 0);
    cfg_row(pdbp_pkg::REG_SIZE3, 63);
    cfg_row(pdbp_pkg::REG_DIR,   8'hE1);
    cmd_row(pdbp_pkg::CMD_WRITE,    0, 32'hFFFF_FFFF, 8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_WRITE,    1, 32'hFFFF_FFFF, 8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_WRITE,    2, 32'hFFFF_FFFF, 8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_WRITE,    3, 32'h8000_0001, 8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_READ,     2, 32'h0,         8'h00, 1, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_READ,     0, 32'h0,         8'h00, 1, 32'hFFFF_FFFF, 8'h00);
    cmd_row(pdbp_pkg::CMD_EXCHANGE, 0, 32'h0,         8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'hFF, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h5A, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h80, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h01, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'hC3, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h7E, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'hFF, 0, 32'h0,         8'h00);
    // cursor already at the end, byte is dropped
    cmd_row(pdbp_pkg::CMD_HOST,     0, 32'h0,         8'h55, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_READ,     3, 32'h0,         8'h00, 0, 32'h0,         8'h00);
    cmd_row(pdbp_pkg::CMD_EXCHANGE, 0, 32'h0,         8'h00, 0, 32'h0,         8'h00);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < script.size(); k++) begin
      if (script[k].is_reg) begin
        drain(QUIET_CYCLES);
        write_reg(script[k].reg_sel, script[k].data);
      end else begin
        offer(script[k].item, script[k].typed, script[k].reply);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          src_idle_pct = 15;
          snk_idle_pct = 50;
        end
        1: begin
          src_idle_pct = 50;
          snk_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      drain(QUIET_CYCLES);
      case (ph)
        0: set_fields(4, 32, 32, 32, 32, 8'h00);
        1: set_fields(7, 63, 0, 1, 33, 8'hFF);
        2: set_fields(4, 1, 1, 1, 1, 8'hAA);
        3: set_fields(0, size_pick(), size_pick(), size_pick(), size_pick(),
                      $urandom_range(0, 255));
        default: set_fields($urandom_range(0, 7), size_pick(), size_pick(), size_pick(),
                            size_pick(), $urandom_range(0, 255));
      endcase
      // long receiver stall while the sender keeps offering
      if (ph == 6) hold_asks++;
      run_phase(PHASE_ITEMS, ph == 7);
    end

    drain(TAIL_CYCLES);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("process_data_bit_packer regression: pass");
    end else begin
      if (reply_q.size() != 0) $error("%0d results never arrived", reply_q.size());
      $display("process_data_bit_packer regression: fail");
    end
    $finish;
  end

endmodule
